// ----- rtl/core/conv2d_valid_window_mac_core_assert.svh -----
// ----------------------------------------------------------------------------
// conv2d valid-window mac assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CONV2D_VALID_WINDOW_MAC_CORE_ASSERT_SVH
`define CONV2D_VALID_WINDOW_MAC_CORE_ASSERT_SVH

// same-cycle implication
`define C2D_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define C2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/conv2d_pkg.sv -----
// ----------------------------------------------------------------------------
// conv2d package
// types and constants of the 5x5 valid-region convolution core
// ----------------------------------------------------------------------------
package conv2d_pkg;

  localparam int KSIZE     = 5;
  localparam int NUM_COEF  = KSIZE * KSIZE;
  localparam int NUM_LINES = KSIZE - 1;
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 11;
  localparam int WIDTH_W   = 11;
  localparam int SLOT_W    = $clog2(NUM_LINES);
  localparam int PIX_W     = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = PIX_W + COEF_W + 1;
  localparam int ROWSUM_W  = PROD_W + 3;
  localparam int SUM_W     = 37;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LANES     = CFG_DATA_W / COEF_W;
  localparam int FULL_WORDS = 6;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(64);

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_IMG_WIDTH = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COEF_W0   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COEF_W6   = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] conv_sum;
    logic                    frame_last;
  } out_item_t;

endpackage

// ----- rtl/core/conv2d_valid_window_mac_core.sv -----
// ----------------------------------------------------------------------------
// conv2d valid-window mac core
// streaming 5x5 true convolution over the valid region of a raster image
// ----------------------------------------------------------------------------
// Pixels (unsigned Q0.16) enter in raster order, one transfer per clock
// while in_ready holds high; each pixel whose row and column are both at
// least 4 completes a 5x5 window and yields one signed Q9.28 sum of 25
// products with the flipped kernel (signed Q4.12 coefficients), frame_last
// set on the frame's last pixel. Other pixels, and every pixel when the row
// width is below 5, give no result. The line memories are read as the
// input transfer is taken, the window then shifts and the 25 multiplies
// run in parallel into the product registers, then the row sums are
// registered, and the final sum lands in the output register that drives
// out_valid. Throughput is one pixel per clock while out_ready holds no
// stage back, set by the single read and write port of each of the four
// 1024 x 16 line memories. The line memories need no clearing after reset;
// an entry is only used once written in the same frame. Registers must be
// written through cfg_* only while the core is idle; the core itself does
// not enforce this. img_width above 1024 acts as 1024 and width 0 as 1.
// ----------------------------------------------------------------------------
`include "conv2d_valid_window_mac_core_assert.svh"

module conv2d_valid_window_mac_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // configuration
  input  logic                                     cfg_we,
  input  logic [conv2d_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [conv2d_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  // pixel input
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  conv2d_pkg::in_item_t                     in_data,
  // result output
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output conv2d_pkg::out_item_t                    out_data
);

  localparam int K     = conv2d_pkg::KSIZE;
  localparam int NL    = conv2d_pkg::NUM_LINES;
  localparam int NC    = conv2d_pkg::NUM_COEF;
  localparam int PW    = conv2d_pkg::PIX_W;
  localparam int CW    = conv2d_pkg::COEF_W;
  localparam int COLW  = conv2d_pkg::COL_W;
  localparam int ROWW  = conv2d_pkg::ROW_W;
  localparam int WW    = conv2d_pkg::WIDTH_W;
  localparam int SW    = conv2d_pkg::SLOT_W;
  localparam int PRW   = conv2d_pkg::PROD_W;
  localparam int RSW   = conv2d_pkg::ROWSUM_W;
  localparam int SUMW  = conv2d_pkg::SUM_W;

  // configuration registers
  logic [WW-1:0]          img_width_r;
  logic signed [CW-1:0]   coef_r [NC];

  // frame position
  logic [COLW-1:0]        col_count_r;
  logic [ROWW-1:0]        row_count_r;

  // stage 1: line memory read data and the pixel
  logic                   v1_r;
  logic                   emit1_r;
  logic                   fend1_r;
  logic [PW-1:0]          pix1_r;
  logic [SW-1:0]          slot1_r;
  logic [PW-1:0]          rd_r [NL];

  // window and stage 2 products
  logic [PW-1:0]          win_r   [K][K];
  logic [PW-1:0]          win_nxt [K][K];
  logic                   v2_r;
  logic                   fl2_r;
  logic signed [PRW-1:0]  prod_r  [K][K];

  // stage 3 row sums
  logic                   v3_r;
  logic                   fl3_r;
  logic signed [RSW-1:0]  rs_r [K];

  // output register
  logic                   out_valid_r;
  conv2d_pkg::out_item_t  out_data_r;

  // line memories, one per buffered row
  logic [PW-1:0]          line_mem [NL][conv2d_pkg::MAX_WIDTH];

  // stage enables: a stage moves when its successor is empty or moving
  logic en2, en3, en4;
  logic in_accept;

  assign en4       = !out_valid_r || out_ready;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign in_ready  = !v1_r || en2;
  assign in_accept = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // effective width and position decode for the incoming pixel
  logic [WW-1:0] w_eff;
  logic [WW-1:0] col_next;
  logic          row_wrap;
  logic          emit0;

  always_comb begin
    if (img_width_r > WW'(conv2d_pkg::MAX_WIDTH)) begin
      w_eff = WW'(conv2d_pkg::MAX_WIDTH);
    end else if (img_width_r == '0) begin
      w_eff = WW'(1);
    end else begin
      w_eff = img_width_r;
    end
    col_next = WW'(col_count_r) + WW'(1);
    row_wrap = (col_next >= w_eff);
    // window complete: enough columns in this row and enough rows buffered
    emit0    = (w_eff >= WW'(K)) && (col_count_r >= COLW'(K - 1)) &&
               (row_count_r >= ROWW'(K - 1));
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r <= conv2d_pkg::WIDTH_RESET;
      for (int i = 0; i < NC; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_addr == conv2d_pkg::CFG_IMG_WIDTH) begin
        img_width_r <= cfg_wdata[WW-1:0];
      end
      for (int wd = 0; wd < conv2d_pkg::FULL_WORDS; wd++) begin
        if (cfg_addr == conv2d_pkg::CFG_COEF_W0 + conv2d_pkg::CFG_ADDR_W'(wd)) begin
          for (int ln = 0; ln < conv2d_pkg::LANES; ln++) begin
            if (wd * conv2d_pkg::LANES + ln < NC) begin
              coef_r[wd * conv2d_pkg::LANES + ln] <= cfg_wdata[ln*CW +: CW];
            end
          end
        end
      end
      if (cfg_addr == conv2d_pkg::CFG_COEF_W6) begin
        coef_r[NC-1] <= cfg_wdata[CW-1:0];
      end
    end
  end

  // column and row counters, restart after frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (in_accept) begin
      if (in_data.frame_end) begin
        col_count_r <= '0;
        row_count_r <= '0;
      end else if (row_wrap) begin
        col_count_r <= '0;
        row_count_r <= row_count_r + ROWW'(1);
      end else begin
        col_count_r <= col_next[COLW-1:0];
      end
    end
  end

  // line memories: read all rows at the column, write the pixel into the
  // row slot of the current row; the read returns the old entry
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int k = 0; k < NL; k++) begin
        rd_r[k] <= line_mem[k][col_count_r];
      end
      line_mem[row_count_r[SW-1:0]][col_count_r] <= in_data.pixel;
    end
  end

  // stage 1 control and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ready) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      emit1_r <= emit0;
      fend1_r <= in_data.frame_end;
      pix1_r  <= in_data.pixel;
      slot1_r <= row_count_r[SW-1:0];
    end
  end

  // window shift: older columns move left, new column enters on the right;
  // window row kr takes the line slot of row (row + kr), bottom row the pixel
  always_comb begin
    for (int kr = 0; kr < K; kr++) begin
      for (int kc = 0; kc < K - 1; kc++) begin
        win_nxt[kr][kc] = win_r[kr][kc+1];
      end
      if (kr < K - 1) begin
        win_nxt[kr][K-1] = rd_r[slot1_r + SW'(kr)];
      end else begin
        win_nxt[kr][K-1] = pix1_r;
      end
    end
  end

  // window update for every pixel, products only for emitting ones
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      for (int kr = 0; kr < K; kr++) begin
        for (int kc = 0; kc < K; kc++) begin
          win_r[kr][kc] <= '0;
        end
      end
    end else if (en2) begin
      v2_r <= v1_r && emit1_r;
      if (v1_r) begin
        win_r <= win_nxt;
      end
    end
  end

  // 25 parallel multiplies against the flipped kernel
  always_ff @(posedge clk) begin
    if (en2 && v1_r && emit1_r) begin
      fl2_r <= fend1_r;
      for (int kr = 0; kr < K; kr++) begin
        for (int kc = 0; kc < K; kc++) begin
          prod_r[kr][kc] <= $signed({1'b0, win_nxt[kr][kc]}) *
                            coef_r[NC - 1 - (kr * K + kc)];
        end
      end
    end
  end

  // row sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [RSW-1:0] acc;
    if (en3 && v2_r) begin
      fl3_r <= fl2_r;
      for (int kr = 0; kr < K; kr++) begin
        acc = '0;
        for (int kc = 0; kc < K; kc++) begin
          acc = acc + RSW'(prod_r[kr][kc]);
        end
        rs_r[kr] <= acc;
      end
    end
  end

  // final sum into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en4) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [RSW+2:0] tot;
    if (en4 && v3_r) begin
      tot = '0;
      for (int kr = 0; kr < K; kr++) begin
        tot = tot + (RSW+3)'(rs_r[kr]);
      end
      out_data_r.conv_sum   <= tot[SUMW-1:0];
      out_data_r.frame_last <= fl3_r;
    end
  end

  // a completed window must reach stage 1 marked for a result
  `C2D_ASSERT_NEXT(a_emit_enters, in_accept && emit0, v1_r && emit1_r, "window lost at stage 1")
  // frame end restarts the position counters
  `C2D_ASSERT_NEXT(a_frame_restart, in_accept && in_data.frame_end, (col_count_r == '0) && (row_count_r == '0), "counters not restarted")
  // input only stalls when every stage is full and the output is held
  `C2D_ASSERT_SAME(a_stall_full, !in_ready, v1_r && v2_r && v3_r && out_valid_r && !out_ready, "stall with a free stage")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv2d valid-window mac core testbench
// raster frames of random pixels go through the 5x5 convolution core with
// random gaps on both handshakes; every window sum is checked against a
// local model of the line buffers, the window and the row/column counters
// ----------------------------------------------------------------------------
module tb_top;

  localparam int KSIZE      = conv2d_pkg::KSIZE;
  localparam int NUM_COEF   = conv2d_pkg::NUM_COEF;
  localparam int NUM_LINES  = conv2d_pkg::NUM_LINES;
  localparam int MAX_WIDTH  = conv2d_pkg::MAX_WIDTH;
  localparam int ROW_W      = conv2d_pkg::ROW_W;
  localparam int WIDTH_W    = conv2d_pkg::WIDTH_W;
  localparam int PIX_W      = conv2d_pkg::PIX_W;
  localparam int COEF_W     = conv2d_pkg::COEF_W;
  localparam int SUM_W      = conv2d_pkg::SUM_W;
  localparam int CFG_ADDR_W = conv2d_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = conv2d_pkg::CFG_DATA_W;
  localparam int LANES      = conv2d_pkg::LANES;
  localparam int FULL_WORDS = conv2d_pkg::FULL_WORDS;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMG_WIDTH = conv2d_pkg::CFG_IMG_WIDTH;
  localparam logic [CFG_ADDR_W-1:0] CFG_COEF_W0   = conv2d_pkg::CFG_COEF_W0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COEF_W6   = conv2d_pkg::CFG_COEF_W6;

  typedef conv2d_pkg::in_item_t  in_item_t;
  typedef conv2d_pkg::out_item_t out_item_t;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int RANDOM_ITEMS = 1650;
  localparam int MAX_GAP      = 16;
  localparam int SETTLE_WAIT  = 12;   // wait longer than the pipeline takes to drain
  localparam int ROW_WRAP     = 1 << ROW_W;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  // one line of the directed stimulus: a register write or a run of pixels;
  // typed rows carry a sum that can be worked out by hand
  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_ADDR_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]   val;
    logic [PIX_W-1:0]        pixel;
    logic                    frame_end;
    int                      reps;
    logic                    typed;
    logic signed [SUM_W-1:0] sum_exp;
    logic                    last_exp;
  } stim_row_t;

  localparam logic [CFG_DATA_W-1:0] ALL_MIN = {LANES{16'h8000}};
  localparam int N_DIR = 15;

  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    // width 5 with the reset coefficients: the one window sums to zero
    '{ROW_CFG, CFG_IMG_WIDTH, 64'd5, 16'h0000, 1'b0, 1, 1'b0, 37'sd0, 1'b0},
    '{ROW_PIX, CFG_IMG_WIDTH, 64'd0, 16'hFFFF, 1'b0, 24, 1'b0, 37'sd0, 1'b0},
    '{ROW_PIX, CFG_IMG_WIDTH, 64'd0, 16'hFFFF, 1'b1, 1, 1'b1, 37'sd0, 1'b1},
    // most negative coefficient everywhere, full-scale pixels
    '{ROW_CFG, CFG_COEF_W0, ALL_MIN, 16'h0000, 1'b0, 1, 1'b0, 37'sd0, 1'b0},
    '{ROW_CFG, CFG_COEF_W0 + 3'd1, ALL_MIN, 16'h0000, 1'b0, 1, 1'b0, 37'sd0, 1'b0},
    '{ROW_CFG, CFG_COEF_W0 + 3'd2, ALL_MIN, 16'h0000, 1'b0, 1, 1'b0, 37'sd0, 1'b0},
    '{ROW_CFG, CFG_COEF_W0 + 3'd3, ALL_MIN, 16'h0000, 1'b0, 1, 1'b0, 37'sd0, 1'b0},
    '{ROW_CFG, CFG_COEF_W0 + 3'd4, ALL_MIN, 16'h0000, 1'b0, 1, 1'b0, 37'sd0, 1'b0},
    '{ROW_CFG, CFG_COEF_W0 + 3'd5, ALL_MIN, 16'h0000, 1'b0, 1, 1'b0, 37'sd0, 1'b0},
    // upper bits of the last word are don't-care
    '{ROW_CFG, CFG_COEF_W6, 64'hFFFF_FFFF_FFFF_8000, 16'h0000, 1'b0, 1, 1'b0,
      37'sd0, 1'b0},
    '{ROW_PIX, CFG_IMG_WIDTH, 64'd0, 16'hFFFF, 1'b0, 24, 1'b0, 37'sd0, 1'b0},
    '{ROW_PIX, CFG_IMG_WIDTH, 64'd0, 16'hFFFF, 1'b1, 1, 1'b1, -37'sd53686272000,
      1'b1},
    // width 0 behaves as width 1: never a full window, frame end gives nothing
    '{ROW_CFG, CFG_IMG_WIDTH, 64'd0, 16'h0000, 1'b0, 1, 1'b0, 37'sd0, 1'b0},
    '{ROW_PIX, CFG_IMG_WIDTH, 64'd0, 16'h0000, 1'b0, 3, 1'b0, 37'sd0, 1'b0},
    '{ROW_PIX, CFG_IMG_WIDTH, 64'd0, 16'hFFFF, 1'b1, 1, 1'b0, 37'sd0, 1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;

  conv2d_valid_window_mac_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // shadow of the core: line buffers, window, counters and registers
  logic [PIX_W-1:0]      line_mem [NUM_LINES][MAX_WIDTH];
  logic [PIX_W-1:0]      win [KSIZE][KSIZE];
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [WIDTH_W-1:0]    width_set;
  logic [CFG_DATA_W-1:0] coef_set [FULL_WORDS+1];

  // window sums still owed by the core, oldest first
  out_item_t sums_due [$];

  int errors      = 0;
  int sent_items  = 0;
  bit send_calm   = 1'b0;
  bit recv_calm   = 1'b0;

  // --------------------------------------------------------------------------
  // clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // shadow model
  // --------------------------------------------------------------------------
  function automatic void model_reset();
    width_set = conv2d_pkg::WIDTH_RESET;
    foreach (coef_set[i]) coef_set[i] = '0;
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void model_config(input logic [CFG_ADDR_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_IMG_WIDTH) begin
      width_set = val[WIDTH_W-1:0];
    end else if (idx == CFG_COEF_W6) begin
      coef_set[FULL_WORDS] = CFG_DATA_W'(val[COEF_W-1:0]);
    end else begin
      coef_set[idx - CFG_COEF_W0] = val;
    end
  endfunction

  // row width as the core applies it: 0 acts as 1, beyond the buffers clamps
  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_set;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (w == 0) w = 1;
    return w;
  endfunction

  function automatic longint coef_of(input int unsigned n);
    logic [CFG_DATA_W-1:0]    word;
    logic signed [COEF_W-1:0] c;
    word = coef_set[n / LANES];
    c = word[(n % LANES) * COEF_W +: COEF_W];
    return longint'(c);
  endfunction

  // shift one pixel into the window and line buffers; returns 1 with the
  // window sum when the pixel closes a full 5x5 window (kernel flipped)
  function automatic bit convolve_pixel(input in_item_t px, output out_item_t res);
    int unsigned w;
    int unsigned col;
    longint      acc;
    longint      pv;
    bit          hit;
    w = eff_width();
    col = col_pos % MAX_WIDTH;
    for (int kr = 0; kr < KSIZE; kr++) begin
      for (int kc = 0; kc < KSIZE - 1; kc++) win[kr][kc] = win[kr][kc+1];
      if (kr < KSIZE - 1) begin
        win[kr][KSIZE-1] = line_mem[(row_pos + kr) % NUM_LINES][col];
      end else begin
        win[kr][KSIZE-1] = px.pixel;
      end
    end
    line_mem[row_pos % NUM_LINES][col] = px.pixel;

    hit = (w >= KSIZE) && (col >= KSIZE - 1) && (row_pos >= KSIZE - 1);
    res = '0;
    if (hit) begin
      acc = 0;
      for (int kr = 0; kr < KSIZE; kr++) begin
        for (int kc = 0; kc < KSIZE; kc++) begin
          pv = win[kr][kc];
          acc += pv * coef_of(NUM_COEF - 1 - (kr * KSIZE + kc));
        end
      end
      res.conv_sum   = acc[SUM_W-1:0];
      res.frame_last = px.frame_end;
    end

    if (px.frame_end) begin
      col_pos = 0;
      row_pos = 0;
    end else if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) % ROW_WRAP;
    end else begin
      col_pos = col + 1;
    end
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // pixel side
  // --------------------------------------------------------------------------

  // one pixel transfer after a random gap; the sum owed is booked at the
  // accepting edge, either from the model or as typed in the directed rows
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fe,
                            input bit typed = 1'b0, input out_item_t typed_res = '0);
    int        gap;
    bit        hit;
    in_item_t  item;
    out_item_t res;
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
    item.pixel = pix;
    item.frame_end = fe;
    // valid drops only when there is a real gap, so it never toggles in one step
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    hit = convolve_pixel(item, res);
    if (typed) begin
      sums_due.push_back(typed_res);
    end else if (hit) begin
      sums_due.push_back(res);
    end
    sent_items++;
  endtask

  // hold off the pixel stream until every owed sum is out and the pipeline
  // has emptied; always lets time pass
  task automatic settle();
    in_valid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // register write, only called once the core has settled
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    model_config(idx, val);
  endtask

  // new row width and a fresh (possibly partial) set of coefficients
  task automatic new_setup();
    int                    pick;
    int                    style;
    logic [CFG_DATA_W-1:0] word;
    logic [CFG_ADDR_W-1:0] idx;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        write_reg(CFG_IMG_WIDTH, CFG_DATA_W'($urandom_range(0, KSIZE - 1)));
      end
      1: begin
        write_reg(CFG_IMG_WIDTH, CFG_DATA_W'($urandom_range(13, 40)));
      end
      default: begin
        write_reg(CFG_IMG_WIDTH, CFG_DATA_W'($urandom_range(KSIZE, 12)));
      end
    endcase
    style = $urandom_range(0, 7);
    for (int i = 0; i <= FULL_WORDS; i++) begin
      if (style == 0) begin
        word = {LANES{16'h8000}};
      end else if (style == 1) begin
        word = {LANES{16'h7FFF}};
      end else begin
        word = {$urandom, $urandom};
      end
      idx = (i == FULL_WORDS) ? CFG_COEF_W6 : CFG_ADDR_W'(CFG_COEF_W0 + i);
      // random styles keep some of the old words
      if (style < 2 || $urandom_range(0, 3) != 0) write_reg(idx, word);
    end
  endtask

  // one frame at the current width; mostly whole rows, sometimes cut short,
  // sometimes narrowed in the middle of a row
  task automatic run_frame();
    int w;
    int rows;
    int total;
    int cut_at;
    int cut_col;
    int style;
    logic [PIX_W-1:0] pix;
    w = eff_width();
    rows = $urandom_range(0, 9);
    total = (rows + 1) * w;
    if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total);
    cut_at = -1;
    cut_col = 0;
    // narrowing only from a column at or past the new width, never wider,
    // so every buffered pixel a window uses comes from this frame
    if (w >= KSIZE + 1 && $urandom_range(0, 7) == 0) begin
      cut_col = $urandom_range(KSIZE, w - 1);
      cut_at = $urandom_range(0, rows) * w + cut_col;
      if (cut_at >= total) cut_at = -1;
    end
    style = $urandom_range(0, 3);
    for (int n = 0; n < total; n++) begin
      if (n == cut_at) begin
        settle();
        write_reg(CFG_IMG_WIDTH, CFG_DATA_W'($urandom_range(0, cut_col)));
      end else if ($urandom_range(0, 299) == 0) begin
        settle();
      end
      if (style == 0 && $urandom_range(0, 1) == 1) begin
        pix = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      end else begin
        pix = PIX_W'($urandom);
      end
      send_pixel(pix, n == total - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: random ready gaps, each transfer checked against the
  // oldest owed sum
  // --------------------------------------------------------------------------
  initial begin : result_side
    int        gap;
    out_item_t got;
    out_item_t want;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
      gap = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = out_data;
      if (sums_due.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result: expected none, actual sum %0d last %0b",
                 $time, got.conv_sum, got.frame_last);
      end else begin
        want = sums_due.pop_front();
        if (got.conv_sum !== want.conv_sum) begin
          errors++;
          $display("%0t ns: conv_sum mismatch: expected %0d, actual %0d",
                   $time, want.conv_sum, got.conv_sum);
        end
        if (got.frame_last !== want.frame_last) begin
          errors++;
          $display("%0t ns: frame_last mismatch: expected %0b, actual %0b",
                   $time, want.frame_last, got.frame_last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    out_item_t typed_res;
    int        base;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: reset coefficients, extreme pixels and coefficients,
    // degenerate width, frame end with no window
    for (int r = 0; r < N_DIR; r++) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        settle();
        write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].val);
      end else begin
        typed_res.conv_sum   = DIR_ROWS[r].sum_exp;
        typed_res.frame_last = DIR_ROWS[r].last_exp;
        for (int n = 0; n < DIR_ROWS[r].reps; n++)
          send_pixel(DIR_ROWS[r].pixel, DIR_ROWS[r].frame_end, DIR_ROWS[r].typed,
                     typed_res);
      end
    end

    // random frames, re-setup between frames only once the core is idle
    base = sent_items;
    while (sent_items - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        new_setup();
      end
      run_frame();
    end

    // wait out every owed sum, then the pipeline depth
    settle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
